// ===== design/crc16m_pkg.sv =====
// shared types, constants and the byte-wise crc update for the crc16 / xor checksum core
package crc16m_pkg;

  localparam int unsigned CheckW = 16;
  localparam int unsigned ByteW  = 8;

  localparam logic [CheckW-1:0] CrcInit  = 16'hFFFF;
  localparam logic [CheckW-1:0] CrcPoly  = 16'hA001;
  localparam logic [CheckW-1:0] XorBase  = 16'hF5F5;
  localparam logic [CheckW-1:0] SeedMult = 16'h0F1F;

  // configuration register indexes
  localparam logic CfgXorMode  = 1'b0;
  localparam logic CfgModeSeed = 1'b1;

  typedef struct packed {
    logic              xor_mode;
    logic [CheckW-1:0] xor_init;
  } crc16m_cfg_t;

  // eight reflected shift steps of crc-16/modbus over one byte
  function automatic logic [CheckW-1:0] crc16m_crc_byte(input logic [CheckW-1:0] v,
                                                        input logic [ByteW-1:0]  b);
    logic [CheckW-1:0] c;
    c = v ^ {{(CheckW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crc16m_cfg.sv =====
// configuration registers and the precomputed seeded start value of the xor mode
module crc16m_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [15:0]                cfg_wdata_i,
  output crc16m_pkg::crc16m_cfg_t    cfg_o
);
  import crc16m_pkg::*;

  logic              xor_mode_q, xor_mode_d;
  logic [CheckW-1:0] xor_init_q, xor_init_d;
  logic [2*CheckW-1:0] seed_prod;

  // full product of seed and multiplier; its low half is used
  assign seed_prod = cfg_wdata_i * SeedMult;

  always_comb begin
    xor_mode_d = xor_mode_q;
    xor_init_d = xor_init_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgXorMode:  xor_mode_d = cfg_wdata_i[0];
        CfgModeSeed: xor_init_d = XorBase ^ seed_prod[CheckW-1:0];
        default:     xor_mode_d = xor_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_mode_q <= 1'b0;
      xor_init_q <= XorBase; // seed of zero
    end else begin
      xor_mode_q <= xor_mode_d;
      xor_init_q <= xor_init_d;
    end
  end

  assign cfg_o.xor_mode = xor_mode_q;
  assign cfg_o.xor_init = xor_init_q;

endmodule

// ===== design/crc16m_step.sv =====
// next running check value for one byte: start value select, then crc or xor update
module crc16m_step (
  input  crc16m_pkg::crc16m_cfg_t cfg_i,
  input  logic                    in_message_i,
  input  logic [15:0]             running_i,
  input  logic [7:0]              data_byte_i,
  output logic [15:0]             next_o
);
  import crc16m_pkg::*;

  logic [CheckW-1:0] start;

  always_comb begin
    if (in_message_i) begin
      start = running_i;
    end else if (cfg_i.xor_mode) begin
      start = cfg_i.xor_init;
    end else begin
      start = CrcInit;
    end
  end

  always_comb begin
    if (cfg_i.xor_mode) begin
      next_o = start ^ {{(CheckW-ByteW){1'b0}}, data_byte_i};
    end else begin
      next_o = crc16m_crc_byte(start, data_byte_i);
    end
  end

endmodule

// ===== design/crc16_modbus_or_seeded_xor_core.sv =====
// top level of the crc-16/modbus or seeded xor checksum core
//
// usage
//   input channel: in_valid_i / in_stall_o carry one message byte per request
//   (data_byte_i) plus last_byte_i, which closes the message. output channel:
//   out_valid_o / out_stall_i carry one check_value_o per message.
//   a request is taken at a clock edge with valid high and stall low.
// mode select
//   register 0 (xor_mode) picks crc-16/modbus (0) or the seeded xor sum (1);
//   register 1 (mode_seed) sets the xor start value 0xf5f5 ^ (seed*0x0f1f).
//   write the registers only while no message is open and no result pends.
// timing and throughput
//   one byte per cycle while no final byte stalls; the registered check value
//   appears in the cycle after its last byte is taken. eight unrolled crc shift
//   steps sit between the state and the result register; a byte folds when taken.
// stalling
//   non-final bytes are taken even while a result waits at the output; only a
//   final byte stalls, and only when the output register is full and stalled.
// reset
//   rst_ni clears the registers to crc mode with seed 0, closes any open
//   message and empties the output register.
module crc16_modbus_or_seeded_xor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] check_value_o
);
  import crc16m_pkg::*;

  crc16m_cfg_t       cfg;
  logic              in_accept;
  logic              out_take;
  logic [CheckW-1:0] next_check;

  logic              in_message_q, in_message_d;
  logic [CheckW-1:0] running_q, running_d;
  logic              out_valid_q, out_valid_d;
  logic [CheckW-1:0] check_q, check_d;

  crc16m_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  crc16m_step u_step (
    .cfg_i        (cfg),
    .in_message_i (in_message_q),
    .running_i    (running_q),
    .data_byte_i  (data_byte_i),
    .next_o       (next_check)
  );

  // a final byte needs the output slot; anything else never waits
  assign in_stall_o = last_byte_i && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  always_comb begin
    in_message_d = in_message_q;
    running_d    = running_q;
    out_valid_d  = out_valid_q && !out_take;
    check_d      = check_q;
    if (in_accept) begin
      running_d    = next_check;
      in_message_d = !last_byte_i;
      if (last_byte_i) begin
        out_valid_d = 1'b1;
        check_d     = next_check;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_message_q <= 1'b0;
      running_q    <= CrcInit;
      out_valid_q  <= 1'b0;
    end else begin
      in_message_q <= in_message_d;
      running_q    <= running_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    check_q <= check_d;
  end

  assign out_valid_o   = out_valid_q;
  assign check_value_o = check_q;

endmodule

// ===== design/crc16m_checker.sv =====
// port-level checks for the checksum core and their bind
module crc16m_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] check_value_o
);

  // a waiting result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(check_value_o))
    else $error("result changed while stalled");

  // a taken final byte yields a result next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> out_valid_o)
    else $error("no result after final byte");

  // a middle byte with a free output slot yields nothing
  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_byte_i && !(out_valid_o && out_stall_i)
    |=> !out_valid_o)
    else $error("result without final byte");

  // input stalls only for a final byte facing a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> last_byte_i && out_valid_o && out_stall_i)
    else $error("input stalled without cause");

endmodule

bind crc16_modbus_or_seeded_xor_core crc16m_checker u_crc16m_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_byte_i   (last_byte_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .check_value_o (check_value_o)
);

// ===== test/check_value_checker.sv =====
// predicts check values from observed requests and compares them with the results
module check_value_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] check_value_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import crc16m_pkg::*;

  localparam logic [15:0] ModbusStart = 16'hFFFF;
  localparam logic [15:0] ModbusPoly  = 16'hA001;
  localparam logic [15:0] XorStart    = 16'hF5F5;
  localparam logic [15:0] XorSeedMul  = 16'h0F1F;

  logic        xor_mode_q;
  logic [15:0] seed_q;
  logic [15:0] running_q;
  logic        msg_open_q;
  logic [15:0] next_val;
  logic [15:0] want_val;
  logic [15:0] check_value_q[$];

  function automatic logic [15:0] modbus_fold(input logic [15:0] v, input logic [7:0] b);
    logic [15:0] r;
    r = v ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ ModbusPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] message_start(input logic xm, input logic [15:0] seed);
    logic [31:0] prod;
    prod = {16'h0000, seed} * {16'h0000, XorSeedMul};
    return xm ? (XorStart ^ prod[15:0]) : ModbusStart;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: check error: %s", $time, what);
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_mode_q = 1'b0;
      seed_q     = 16'h0000;
      running_q  = ModbusStart;
      msg_open_q = 1'b0;
      check_value_q.delete();
      pending_o   <= 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgXorMode) begin
          xor_mode_q = cfg_wdata_i[0];
        end else begin
          seed_q = cfg_wdata_i;
        end
      end
      // results first: a result taken now belongs to an earlier message
      if (out_valid_i && !out_stall_i) begin
        if (check_value_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", check_value_i));
        end else begin
          want_val = check_value_q.pop_front();
          if (check_value_i !== want_val) begin
            report_mismatch($sformatf("check_value %h, want %h", check_value_i, want_val));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_val = msg_open_q ? running_q : message_start(xor_mode_q, seed_q);
        next_val = xor_mode_q ? (next_val ^ {8'h00, data_byte_i})
                              : modbus_fold(next_val, data_byte_i);
        running_q = next_val;
        if (last_byte_i) begin
          check_value_q.push_back(next_val);
          msg_open_q = 1'b0;
        end else begin
          msg_open_q = 1'b1;
        end
      end
      pending_o <= check_value_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// stimulus and verdict for the crc-16/modbus or seeded xor checksum core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16m_pkg::*;

  // generous bound: ~400 requests, each at worst a full gap plus a full stall
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseBytes = 40;
  localparam int unsigned NumPhases  = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] check_value_o;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  // quiet switches all idling off for the closing stretch
  logic        quiet       = 1'b0;
  int unsigned send_run    = 0;
  int unsigned stall_hold  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  crc16_modbus_or_seeded_xor_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .check_value_o(check_value_o)
  );

  check_value_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .check_value_i(check_value_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: stall bursts of random length between open runs of random length
  initial begin
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (stall_hold != 0) begin
        stall_hold = stall_hold - 1;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        stall_hold = $urandom_range(30, 0);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(13, 0);
      end
    end
  end

  // one byte request; returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    // gap burst of random length after a run of 1 to 30 requests
    if (!quiet && send_run == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk_i);
      send_run = $urandom_range(30, 1);
    end
    if (send_run != 0) begin
      send_run = send_run - 1;
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // a message of random bytes, biased toward the byte extremes
  task automatic send_message(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(7, 0))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // close the request stream and wait until every check value is back,
  // then give the result register time to settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers back to back; upper bits of the mode write are junk
  task automatic write_config(input logic xm, input logic [15:0] seed);
    logic [15:0] w;
    w    = 16'($urandom);
    w[0] = xm;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgXorMode;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= CfgModeSeed;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    logic        xm;
    logic [15:0] seed;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // crc mode with a seed that must have no effect
    write_config(1'b0, 16'hFFFF);
    // standard check string "123456789"
    for (int i = 0; i < 9; i++) begin
      send_byte(8'h31 + 8'(i), i == 8);
    end
    // one-byte messages at the byte extremes, then a four-byte message
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_idle();

    // xor mode, zero seed gives the bare base value
    write_config(1'b1, 16'h0000);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_idle();

    // xor mode, largest seed
    write_config(1'b1, 16'hFFFF);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // random phases rotating through the register settings
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph == NumPhases - 1) begin
        quiet = 1'b1;
      end
      case (ph % 4)
        0: begin
          xm   = 1'b0;
          seed = 16'($urandom);
        end
        1: begin
          xm   = 1'b1;
          seed = 16'($urandom);
        end
        2: begin
          xm   = 1'b1;
          seed = (ph < 4) ? 16'h0000 : 16'hFFFF;
        end
        default: begin
          xm   = 1'b0;
          seed = 16'h0000;
        end
      endcase
      write_config(xm, seed);
      sent = 0;
      while (sent < PhaseBytes) begin
        // mostly short frames, now and then a long one
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
        send_message(len);
        sent = sent + len;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/crc16m_pkg.sv
design/crc16m_cfg.sv
design/crc16m_step.sv
design/crc16_modbus_or_seeded_xor_core.sv
design/crc16m_checker.sv
test/check_value_checker.sv
test/testbench.sv
